// ===== rtl/pcvba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcvba_pkg: shared types and constants of the per-CPU vector allocator
// Sizes of the bitmap store, request/result codes and the reset row pattern.
// ----------------------------------------------------------------------------
package pcvba_pkg;

  localparam int CPU_COUNT    = 256;
  localparam int VECTOR_COUNT = 256;
  localparam int RESERVED_LOW = 32;

  localparam int CPU_W = 8;
  localparam int VEC_W = 8;

  // Search is split into chunks; each chunk gets its own priority encoder
  localparam int CHUNK_W   = 64;
  localparam int CHUNKS    = VECTOR_COUNT / CHUNK_W;
  localparam int LOCAL_W   = $clog2(CHUNK_W);
  localparam int CHUNK_IDX_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  typedef logic [VECTOR_COUNT-1:0] row_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_BAD_CPU   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_FIND
  } state_t;

  // Row value after reset: reserved low vectors marked used
  function automatic row_t reset_row();
    row_t r;
    for (int i = 0; i < VECTOR_COUNT; i++) begin
      r[i] = (i < RESERVED_LOW);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pcvba_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcvba_req_if / pcvba_rsp_if: request and result channels
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pcvba_req_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [pcvba_pkg::CPU_W-1:0] cpu_id;
  logic [pcvba_pkg::VEC_W-1:0] vector_in;

  modport source (output valid, output opcode, output cpu_id, output vector_in,
                  input ready);
  modport sink   (input valid, input opcode, input cpu_id, input vector_in,
                  output ready);
endinterface

interface pcvba_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [pcvba_pkg::VEC_W-1:0] vector_out;
  logic [1:0]                 status;

  modport source (output valid, output vector_out, output status, input ready);
  modport sink   (input valid, input vector_out, input status, output ready);
endinterface
`default_nettype wire

// ===== rtl/pcvba_ffz.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcvba_ffz: find first zero over one bitmap row
// Stage one encodes each chunk into a registered (has-zero, local index);
// the second level picks the lowest chunk with a zero.
// ----------------------------------------------------------------------------
module pcvba_ffz (
  input  wire logic                         clk,
  input  wire pcvba_pkg::row_t              row,
  output logic                              found,
  output logic [pcvba_pkg::VEC_W-1:0]       index
);

  logic [pcvba_pkg::CHUNKS-1:0]  chunk_hit;
  logic [pcvba_pkg::LOCAL_W-1:0] chunk_idx [pcvba_pkg::CHUNKS];
  logic [pcvba_pkg::CHUNKS-1:0]  hit_next;
  logic [pcvba_pkg::LOCAL_W-1:0] idx_next [pcvba_pkg::CHUNKS];

  // Per-chunk priority encode
  always_comb begin
    for (int c = 0; c < pcvba_pkg::CHUNKS; c++) begin
      hit_next[c] = 1'b0;
      idx_next[c] = '0;
      for (int b = pcvba_pkg::CHUNK_W - 1; b >= 0; b--) begin
        if (!row[c * pcvba_pkg::CHUNK_W + b]) begin
          hit_next[c] = 1'b1;
          idx_next[c] = pcvba_pkg::LOCAL_W'(b);
        end
      end
    end
  end

  // Chunk results registered
  always_ff @(posedge clk) begin
    chunk_hit <= hit_next;
    for (int c = 0; c < pcvba_pkg::CHUNKS; c++) begin
      chunk_idx[c] <= idx_next[c];
    end
  end

  // Lowest chunk holding a zero
  always_comb begin
    logic [pcvba_pkg::CHUNK_IDX_W-1:0] sel;
    sel   = '0;
    found = 1'b0;
    for (int c = pcvba_pkg::CHUNKS - 1; c >= 0; c--) begin
      if (chunk_hit[c]) begin
        sel   = pcvba_pkg::CHUNK_IDX_W'(c);
        found = 1'b1;
      end
    end
    index = pcvba_pkg::VEC_W'({sel, chunk_idx[sel]});
  end

endmodule
`default_nettype wire

// ===== rtl/per_cpu_vector_bitmap_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// per_cpu_vector_bitmap_allocator: per-CPU interrupt vector allocator
// Keeps one used-vector bitmap per CPU in a row-wide synchronous memory.
//
// Usage:
//   req carries opcode (alloc / free), cpu_id and vector_in. rsp returns
//   vector_out and status, one result item per request item, in order.
//   Each item runs read, search, write-back: the row is read at accept,
//   chunk encoders are registered in the next cycle, and the chosen vector
//   is written back and the result loaded once the result register is free.
//   req is ready again in the cycle after the result is loaded, so a new
//   item is taken only once the last one has passed the memory read, the
//   registered search and the write-back of its row.
//   Reset clears a per-row valid flag; a row not yet written reads as the
//   power-on pattern (reserved low vectors used), so no clearing pass runs
//   and requests are taken right after reset.
//   A stalled receiver holds the result register; the next item may be
//   accepted and read meanwhile, and its write-back waits for the slot.
// ----------------------------------------------------------------------------
module per_cpu_vector_bitmap_allocator (
  input  wire logic  clk,
  input  wire logic  rst,
  pcvba_req_if.sink  req,
  pcvba_rsp_if.source rsp
);

  pcvba_pkg::state_t state, state_next;

  // Bitmap store and per-row written flags
  pcvba_pkg::row_t               mem [pcvba_pkg::CPU_COUNT];
  logic [pcvba_pkg::CPU_COUNT-1:0] row_valid;

  // Item being worked on
  pcvba_pkg::row_t               rd_data;
  logic                          rd_valid;
  logic                          op;
  logic [pcvba_pkg::CPU_W-1:0]   cpu;
  logic [pcvba_pkg::VEC_W-1:0]   vin;
  logic                          bad_cpu;

  // Result register
  logic                          rsp_valid;
  logic [pcvba_pkg::VEC_W-1:0]   vector_out;
  logic [1:0]                    status;

  pcvba_pkg::row_t               row;
  pcvba_pkg::row_t               wr_data;
  logic                          wr_en;
  logic                          found;
  logic [pcvba_pkg::VEC_W-1:0]   found_idx;
  logic                          out_free;
  logic                          finish;
  logic                          accept;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == pcvba_pkg::S_IDLE);
  assign out_free  = !rsp_valid || rsp.ready;
  assign finish    = (state == pcvba_pkg::S_FIND) && out_free;

  // Unwritten rows read as the power-on pattern
  assign row = rd_valid ? rd_data : pcvba_pkg::reset_row();

  pcvba_ffz u_ffz (
    .clk   (clk),
    .row   (row),
    .found (found),
    .index (found_idx)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcvba_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pcvba_pkg::S_IDLE: if (accept) state_next = pcvba_pkg::S_READ;
      pcvba_pkg::S_READ: state_next = pcvba_pkg::S_FIND;
      pcvba_pkg::S_FIND: if (out_free) state_next = pcvba_pkg::S_IDLE;
      default:           state_next = pcvba_pkg::S_IDLE;
    endcase
  end

  // Row read and request capture at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data  <= mem[req.cpu_id];
      rd_valid <= row_valid[req.cpu_id];
      op       <= req.opcode;
      cpu      <= req.cpu_id;
      vin      <= req.vector_in;
      bad_cpu  <= ({1'b0, req.cpu_id} >= (pcvba_pkg::CPU_W + 1)'(pcvba_pkg::CPU_COUNT));
    end
  end

  // Modified row and write enable
  always_comb begin
    wr_data = row;
    wr_en   = 1'b0;
    if (op == pcvba_pkg::OP_FREE) begin
      wr_data[vin] = 1'b0;
      wr_en = finish && !bad_cpu &&
              ({1'b0, vin} < (pcvba_pkg::VEC_W + 1)'(pcvba_pkg::VECTOR_COUNT));
    end else begin
      wr_data[found_idx] = 1'b1;
      wr_en = finish && !bad_cpu && found;
    end
  end

  // Write-back
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cpu] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[cpu] <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (bad_cpu) begin
        status     <= pcvba_pkg::ST_BAD_CPU;
        vector_out <= '0;
      end else if (op == pcvba_pkg::OP_FREE) begin
        status     <= pcvba_pkg::ST_OK;
        vector_out <= '0;
      end else if (found) begin
        status     <= pcvba_pkg::ST_OK;
        vector_out <= found_idx;
      end else begin
        status     <= pcvba_pkg::ST_EXHAUSTED;
        vector_out <= '0;
      end
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.vector_out = vector_out;
  assign rsp.status     = status;

endmodule
`default_nettype wire
